### hw/rtl/isd_pkg.sv
// Package for the insert/delete string distance block.
// Holds sizes, action codes, item structs, the cell link struct and FSM states.
// No dependencies.
package isd_pkg;

	// Longest string held; one cell per byte of string A
	localparam int MAX_LEN = 64;
	// Holds a length from 0 to MAX_LEN
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	// Holds a distance from 0 to 2*MAX_LEN
	localparam int DP_W = $clog2(2 * MAX_LEN + 1);
	// Holds distance + 1
	localparam int DEN_W = DP_W + 1;
	localparam int CHAR_W = 8;
	localparam int DIST_W = 8;
	localparam int SIM_W = 16;
	// 1.0 in Q1.15
	localparam int SIM_ONE = 32768;
	// Numerator of the reciprocal: SIM_ONE plus half the largest divisor
	localparam int NUM_W = $clog2(SIM_ONE + (1 << DEN_W));
	localparam int STEP_W = $clog2(NUM_W + 1);

	typedef enum logic [1:0] {
		ACT_APPEND_A = 2'd0,
		ACT_APPEND_B = 2'd1,
		ACT_FINISH   = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [CHAR_W-1:0] char_byte;
	} request_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [SIM_W-1:0]  similarity;
		logic              overflow;
	} result_t;

	// Token handed from one cell to the next
	typedef struct packed {
		logic              vld;
		logic              fin;   // finish token: carries the distance, clears cells
		logic [CHAR_W-1:0] ch;    // B byte
		logic [DP_W-1:0]   left;  // updated value of the previous entry
		logic [DP_W-1:0]   diag;  // previous entry's value before this B byte
	} link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_DIVIDE,
		ST_EMIT
	} fsm_t;

endpackage

### hw/rtl/isd_cell.sv
// One cell of the DP chain: holds one byte of A and its row entry.
// Depends on isd_pkg.
module isd_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [isd_pkg::LEN_W-1:0]  idx,
	input  logic                       a_we,
	input  logic [isd_pkg::LEN_W-1:0]  a_addr,
	input  logic [isd_pkg::CHAR_W-1:0] a_data,
	input  isd_pkg::link_t             link_in,
	output isd_pkg::link_t             link_out
);
	import isd_pkg::*;

	logic              act_q;
	logic [CHAR_W-1:0] ch_q;
	logic [DP_W-1:0]   dp_q;
	link_t             link_q;

	logic              hit;
	logic              step;
	logic [DP_W-1:0]   min_val;
	logic [DP_W-1:0]   upd;

	// Row update for one B byte
	always_comb begin
		hit     = a_we && (a_addr == idx);
		step    = link_in.vld && act_q;
		min_val = (dp_q < link_in.left) ? dp_q : link_in.left;
		upd     = (ch_q == link_in.ch) ? link_in.diag : min_val + DP_W'(1);
	end

	// Active flag: set when the A byte lands, cleared by the finish token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (hit) begin
			act_q <= 1'b1;
		end else if (link_in.vld && link_in.fin) begin
			act_q <= 1'b0;
		end
	end

	// Stored byte and entry; the entry starts at its own index
	always_ff @(posedge clk) begin
		if (hit) begin
			ch_q <= a_data;
			dp_q <= DP_W'(idx);
		end else if (step && !link_in.fin) begin
			dp_q <= upd;
		end
	end

	// Token to the next cell; inactive cells pass it unchanged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.vld <= link_in.vld;
			link_q.fin <= link_in.fin;
			link_q.ch  <= link_in.ch;
			if (step && link_in.fin) begin
				link_q.left <= dp_q;
				link_q.diag <= link_in.diag;
			end else if (step) begin
				link_q.left <= upd;
				link_q.diag <= dp_q;
			end else begin
				link_q.left <= link_in.left;
				link_q.diag <= link_in.diag;
			end
		end
	end

	assign link_out = link_q;

endmodule

### hw/rtl/isd_recip.sv
// Restoring divider for the similarity: round-half-up of SIM_ONE / den.
// One quotient bit per cycle. Depends on isd_pkg.
module isd_recip (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [isd_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [isd_pkg::SIM_W-1:0] quot
);
	import isd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;

	logic [DEN_W:0]    trial;
	logic              ge;

	// Shift in the next numerator bit and try to subtract
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			num_q <= NUM_W'(SIM_ONE) + NUM_W'(den >> 1);
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], ge};
			num_q <= {num_q[NUM_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign quot = quo_q[SIM_W-1:0];

endmodule

### hw/rtl/indel_string_distance.sv
// Top level of the insert/delete string distance block.
// Head cell, chain of isd_cell, isd_recip and the finish sequencer. Depends on isd_pkg.
//
//  channel   ports              handshake
//  --------  -----------------  ---------------------------------------
//  request   start, request     taken on clk when start && !busy
//  result    done, result       one cycle, taken on that cycle's clk
//
// A and B bytes are taken one per cycle without raising busy; B bytes may follow each other every cycle
// while their tokens ripple down the MAX_LEN-cell chain, one cell per cycle.
// A finish item holds busy while the token drains the chain and the divider runs
// one bit per cycle, then the result shows for one cycle.
// The finish token also clears every cell it passes.
// Reset is asynchronous and leaves the block empty and idle.
module indel_string_distance (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  isd_pkg::request_t request,
	output logic              done,
	output isd_pkg::result_t  result
);
	import isd_pkg::*;

	fsm_t             state_q, state_d;
	logic [LEN_W-1:0] a_len_q;
	logic [LEN_W-1:0] b_len_q;
	logic [DP_W-1:0]  dp0_q;
	logic             ovf_q;
	link_t            head_q;
	result_t          result_q;

	logic             accept;
	logic             a_we;
	logic [LEN_W-1:0] a_addr;
	logic             tail_fin;
	logic             recip_done;
	logic [SIM_W-1:0] recip_quot;
	link_t            chain [0:MAX_LEN];

	assign accept   = start && !busy;
	assign a_we     = accept && (request.action == ACT_APPEND_A) &&
	                  (b_len_q == '0) && (a_len_q != LEN_W'(MAX_LEN));
	assign a_addr   = a_len_q + LEN_W'(1);
	assign tail_fin = chain[MAX_LEN].vld && chain[MAX_LEN].fin;

	// Head: lengths, entry zero, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_len_q <= '0;
			b_len_q <= '0;
			dp0_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			case (request.action)
				ACT_APPEND_A: begin
					if (a_we) begin
						a_len_q <= a_addr;
					end else begin
						ovf_q <= 1'b1;
					end
				end
				ACT_APPEND_B: begin
					if (b_len_q == LEN_W'(MAX_LEN)) begin
						ovf_q <= 1'b1;
					end else begin
						b_len_q <= b_len_q + LEN_W'(1);
						dp0_q   <= dp0_q + DP_W'(1);
					end
				end
				ACT_FINISH: begin
					a_len_q <= '0;
					b_len_q <= '0;
					dp0_q   <= '0;
					ovf_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Token into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q.vld  <= 1'b0;
			head_q.fin  <= 1'b0;
			head_q.ch   <= request.char_byte;
			head_q.left <= dp0_q + DP_W'(1);
			head_q.diag <= dp0_q;
			if (accept && (request.action == ACT_APPEND_B) &&
			    (b_len_q != LEN_W'(MAX_LEN))) begin
				head_q.vld <= 1'b1;
			end else if (accept && (request.action == ACT_FINISH)) begin
				head_q.vld  <= 1'b1;
				head_q.fin  <= 1'b1;
				head_q.left <= dp0_q;
			end
		end
	end

	assign chain[0] = head_q;

	// Chain of cells, cell g holds byte g of A and entry g+1
	for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
		isd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (LEN_W'(g + 1)),
			.a_we     (a_we),
			.a_addr   (a_addr),
			.a_data   (request.char_byte),
			.link_in  (chain[g]),
			.link_out (chain[g+1])
		);
	end

	isd_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tail_fin),
		.den    (DEN_W'(chain[MAX_LEN].left) + DEN_W'(1)),
		.done   (recip_done),
		.quot   (recip_quot)
	);

	// Finish sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (request.action == ACT_FINISH)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (tail_fin) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (recip_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Finish sequencer: outputs
	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_EMIT: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Result item assembled over the finish sequence
	always_ff @(posedge clk) begin
		if (accept && (request.action == ACT_FINISH)) begin
			result_q.overflow <= ovf_q;
		end
		if (tail_fin) begin
			result_q.distance <= DIST_W'(chain[MAX_LEN].left);
		end
		if (recip_done) begin
			result_q.similarity <= recip_quot;
		end
	end

	assign result = result_q;

endmodule
